// ----- hw/rtl/wpp_pkg.sv -----
// Shared constants and threshold table for the windowed peak-to-peak dB meter.
package wpp_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int SPAN_W       = 12;
  localparam int DB_W         = 7;
  localparam int BAR_W        = 7;
  localparam int WIN_W        = 16;
  localparam int DB_STEPS     = 96;
  localparam int TH_W         = 17;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic CFG_REG_WINDOW = 1'b0;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;

  // bar = floor(db * BAR_WIDTH / DB_CLAMP), exact for db below 128
  localparam int DB_CLAMP   = 150;
  localparam int BAR_WIDTH  = 82;
  localparam int BAR_SHIFT  = 20;
  localparam int BAR_RECIP  = ((1 << BAR_SHIFT) + DB_CLAMP - 1) / DB_CLAMP;
  localparam int BAR_MUL    = BAR_WIDTH * BAR_RECIP;
  localparam int BAR_MUL_W  = 20;

  // least span that rounds to at least d dB, d = 1..96
  localparam logic [TH_W-1:0] DB_THRESH [DB_STEPS] = '{
    17'd2, 17'd2, 17'd2, 17'd2, 17'd2, 17'd2, 17'd3, 17'd3, 17'd3, 17'd3,
    17'd4, 17'd4, 17'd5, 17'd5, 17'd6, 17'd6, 17'd7, 17'd8, 17'd9, 17'd10,
    17'd11, 17'd12, 17'd14, 17'd15, 17'd17, 17'd19, 17'd22, 17'd24, 17'd27, 17'd30,
    17'd34, 17'd38, 17'd43, 17'd48, 17'd54, 17'd60, 17'd67, 17'd75, 17'd85, 17'd95,
    17'd106, 17'd119, 17'd134, 17'd150, 17'd168, 17'd189, 17'd212, 17'd238,
    17'd267, 17'd299, 17'd335, 17'd376, 17'd422, 17'd474, 17'd531, 17'd596,
    17'd669, 17'd750, 17'd842, 17'd945, 17'd1060, 17'd1189, 17'd1334, 17'd1497,
    17'd1679, 17'd1884, 17'd2114, 17'd2372, 17'd2661, 17'd2986, 17'd3350, 17'd3759,
    17'd4217, 17'd4732, 17'd5309, 17'd5957, 17'd6684, 17'd7499, 17'd8414, 17'd9441,
    17'd10593, 17'd11886, 17'd13336, 17'd14963, 17'd16789, 17'd18837, 17'd21135,
    17'd23714, 17'd26608, 17'd29854, 17'd33497, 17'd37584, 17'd42170, 17'd47316,
    17'd53089, 17'd59567
  };

endpackage

// ----- hw/rtl/wpp_tracker.sv -----
// Sample input register, window counter, min/max trackers and span register.
module wpp_tracker #(
  parameter int ADC_BITS = wpp_pkg::ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wpp_pkg::WIN_W-1:0]  window_samples,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ADC_BITS-1:0]        in_sample,
  output logic                       span_valid,
  input  logic                       span_stall,
  output logic [ADC_BITS-1:0]        span
);
  import wpp_pkg::*;

  localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

  logic                s1_v_r;
  logic [ADC_BITS-1:0] s1_sample_r;
  logic [WIN_W-1:0]    cnt_r;
  logic [ADC_BITS-1:0] max_r;
  logic [ADC_BITS-1:0] min_r;
  logic                sp_v_r;
  logic [ADC_BITS-1:0] span_r;

  logic                smp_ok;
  logic [ADC_BITS-1:0] max_nxt;
  logic [ADC_BITS-1:0] min_nxt;
  logic [WIN_W:0]      cnt_inc;
  logic [WIN_W:0]      limit;
  logic                win_end;
  logic [ADC_BITS-1:0] span_nxt;
  logic                sp_free;
  logic                adv;

  always_comb begin
    smp_ok   = (s1_sample_r != FULL_SCALE);
    max_nxt  = (smp_ok && (s1_sample_r > max_r)) ? s1_sample_r : max_r;
    min_nxt  = (smp_ok && (s1_sample_r < min_r)) ? s1_sample_r : min_r;
    cnt_inc  = {1'b0, cnt_r} + {{WIN_W{1'b0}}, 1'b1};
    // zero window length means a full 2^16 samples
    limit    = {(window_samples == '0), window_samples};
    win_end  = (cnt_inc >= limit);
    span_nxt = (max_nxt >= min_nxt) ? (max_nxt - min_nxt) : '0;
    sp_free  = !sp_v_r || !span_stall;
    adv      = s1_v_r && (!win_end || sp_free);
  end

  assign in_stall   = s1_v_r && !adv;
  assign span_valid = sp_v_r;
  assign span       = span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      sp_v_r <= 1'b0;
      cnt_r  <= '0;
      max_r  <= '0;
      min_r  <= FULL_SCALE;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (adv && win_end) begin
        sp_v_r <= 1'b1;
      end else if (!span_stall) begin
        sp_v_r <= 1'b0;
      end
      if (adv) begin
        if (win_end) begin
          cnt_r <= '0;
          max_r <= '0;
          min_r <= FULL_SCALE;
        end else begin
          cnt_r <= cnt_inc[WIN_W-1:0];
          max_r <= max_nxt;
          min_r <= min_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_sample;
    end
    if (adv && win_end) begin
      span_r <= span_nxt;
    end
  end

endmodule

// ----- hw/rtl/wpp_level.sv -----
// Span to dB level and bar fill: threshold compare, encode and scale stages.
module wpp_level #(
  parameter int ADC_BITS = wpp_pkg::ADC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        span_valid,
  output logic                        span_stall,
  input  logic [ADC_BITS-1:0]         span,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wpp_pkg::SPAN_W-1:0]  out_peak_span,
  output logic [wpp_pkg::DB_W-1:0]    out_level_db,
  output logic [wpp_pkg::BAR_W-1:0]   out_bar_fill
);
  import wpp_pkg::*;

  localparam int PROD_W = DB_W + BAR_MUL_W;

  logic                t_v_r;
  logic [DB_STEPS-1:0] therm_r;
  logic [SPAN_W-1:0]   pk_t_r;
  logic                d_v_r;
  logic [DB_W-1:0]     db_r;
  logic [SPAN_W-1:0]   pk_d_r;
  logic                o_v_r;
  logic [SPAN_W-1:0]   o_pk_r;
  logic [DB_W-1:0]     o_db_r;
  logic [BAR_W-1:0]    o_bar_r;

  logic [TH_W-1:0]     span_ext;
  logic [DB_STEPS-1:0] therm_nxt;
  logic [DB_STEPS:0]   therm_pad;
  logic [DB_W-1:0]     db_nxt;
  logic [PROD_W-1:0]   prod;
  logic                en_o;
  logic                en_d;
  logic                en_t;

  always_comb begin
    span_ext = TH_W'(span);
    for (int i = 0; i < DB_STEPS; i++) begin
      therm_nxt[i] = (span_ext >= DB_THRESH[i]);
    end
  end

  // thresholds rise monotonically, so the code is a thermometer and its top edge is the count
  always_comb begin
    therm_pad = {1'b0, therm_r};
    db_nxt    = '0;
    for (int i = 0; i < DB_STEPS; i++) begin
      if (therm_pad[i] && !therm_pad[i+1]) begin
        db_nxt = db_nxt | DB_W'(i + 1);
      end
    end
  end

  assign prod = {{BAR_MUL_W{1'b0}}, db_r} * PROD_W'(BAR_MUL);

  assign en_o       = !o_v_r || !out_stall;
  assign en_d       = !d_v_r || en_o;
  assign en_t       = !t_v_r || en_d;
  assign span_stall = !en_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (en_t) begin
        t_v_r <= span_valid;
      end
      if (en_d) begin
        d_v_r <= t_v_r;
      end
      if (en_o) begin
        o_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_t && span_valid) begin
      therm_r <= therm_nxt;
      pk_t_r  <= span_ext[SPAN_W-1:0];
    end
    if (en_d && t_v_r) begin
      db_r   <= db_nxt;
      pk_d_r <= pk_t_r;
    end
    if (en_o && d_v_r) begin
      o_pk_r  <= pk_d_r;
      o_db_r  <= db_r;
      o_bar_r <= prod[BAR_SHIFT +: BAR_W];
    end
  end

  assign out_valid     = o_v_r;
  assign out_peak_span = o_pk_r;
  assign out_level_db  = o_db_r;
  assign out_bar_fill  = o_bar_r;

endmodule

// ----- hw/rtl/windowed_peak_to_peak_db_meter.sv -----
// Windowed peak-to-peak dB meter: config register and the tracker/level pipeline.
// Throughput: one sample per cycle while in_stall is low; a result per window_samples samples (0 means 65536).
// Stages: input register, span register, threshold compare, dB encode, output register.
// Reset (rst_n, synchronous): pipeline empty, trackers cleared, window_samples = 1000.
module windowed_peak_to_peak_db_meter #(
  parameter int ADC_BITS = wpp_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wpp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wpp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wpp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ADC_BITS-1:0]             in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wpp_pkg::SPAN_W-1:0]      out_peak_span,
  output logic [wpp_pkg::DB_W-1:0]        out_level_db,
  output logic [wpp_pkg::BAR_W-1:0]       out_bar_fill
);
  import wpp_pkg::*;

  logic [WIN_W-1:0]    win_r;
  logic                sel_win;
  logic                span_valid;
  logic                span_stall;
  logic [ADC_BITS-1:0] span;

  assign pready  = 1'b1;
  assign sel_win = (paddr[CFG_ADDR_W-1] == CFG_REG_WINDOW);
  assign prdata  = sel_win ? {{(CFG_DATA_W-WIN_W){1'b0}}, win_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (psel && penable && pwrite && pready && sel_win) begin
      win_r <= pwdata[WIN_W-1:0];
    end
  end

  wpp_tracker #(
    .ADC_BITS(ADC_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .window_samples (win_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .span_valid     (span_valid),
    .span_stall     (span_stall),
    .span           (span)
  );

  wpp_level #(
    .ADC_BITS(ADC_BITS)
  ) u_level (
    .clk           (clk),
    .rst_n         (rst_n),
    .span_valid    (span_valid),
    .span_stall    (span_stall),
    .span          (span),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_peak_span (out_peak_span),
    .out_level_db  (out_level_db),
    .out_bar_fill  (out_bar_fill)
  );

endmodule

// ----- test/windowed_peak_to_peak_db_meter_test.sv -----
// Testbench for the windowed peak-to-peak dB meter: directed and random samples with a scoreboard.
`timescale 1ns / 1ps

module windowed_peak_to_peak_db_meter_test;
  import wpp_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam logic [ADC_W-1:0] FULL_SCALE = '1;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = {CFG_REG_WINDOW, 2'b00};
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 90;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [DB_W-1:0]   db;
    logic [BAR_W-1:0]  bar;
  } reading_t;

  class span_meter_board;
    logic [WIN_W-1:0] window_len;
    int unsigned      seen_count;
    logic [ADC_W-1:0] run_max;
    logic [ADC_W-1:0] run_min;
    reading_t         due_readings[$];
    int               failures;
    int               samples_taken;
    int               readings_checked;

    function new();
      window_len = WIN_RESET;
      clear_trackers();
      failures = 0;
      samples_taken = 0;
      readings_checked = 0;
    endfunction

    function void clear_trackers();
      seen_count = 0;
      run_max = '0;
      run_min = FULL_SCALE;
    endfunction

    function void set_window(logic [WIN_W-1:0] len);
      window_len = len;
    endfunction

    function int pending();
      return due_readings.size();
    endfunction

    function void take_sample(logic [ADC_W-1:0] s);
      int unsigned limit;
      int unsigned db;
      int unsigned clamped;
      logic [ADC_W-1:0] span;
      reading_t r;
      samples_taken++;
      if (s != FULL_SCALE) begin
        if (s > run_max) run_max = s;
        if (s < run_min) run_min = s;
      end
      seen_count++;
      limit = (window_len == 0) ? 65536 : window_len;
      if (seen_count >= limit) begin
        span = (run_max >= run_min) ? run_max - run_min : '0;
        db = 0;
        for (int d = 0; d < DB_STEPS; d++)
          if (TH_W'(span) >= DB_THRESH[d]) db++;
        clamped = (db > DB_CLAMP) ? DB_CLAMP : db;
        r.span = SPAN_W'(span);
        r.db = DB_W'(db);
        r.bar = BAR_W'((clamped * BAR_WIDTH) / DB_CLAMP);
        due_readings.push_back(r);
        clear_trackers();
      end
    endfunction

    function void check_reading(logic [SPAN_W-1:0] span, logic [DB_W-1:0] db,
                                logic [BAR_W-1:0] bar);
      reading_t want;
      if (due_readings.size() == 0) begin
        $display("%0t: unexpected reading span=%0d db=%0d bar=%0d", $time, span, db, bar);
        failures++;
      end else begin
        want = due_readings.pop_front();
        readings_checked++;
        if (span !== want.span) begin
          $display("%0t: peak_span expected %0d got %0d", $time, want.span, span);
          failures++;
        end
        if (db !== want.db) begin
          $display("%0t: level_db expected %0d got %0d", $time, want.db, db);
          failures++;
        end
        if (bar !== want.bar) begin
          $display("%0t: bar_fill expected %0d got %0d", $time, want.bar, bar);
          failures++;
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [ADC_W-1:0]       in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [SPAN_W-1:0]      out_peak_span;
  logic [DB_W-1:0]        out_level_db;
  logic [BAR_W-1:0]       out_bar_fill;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;

  span_meter_board board = new();

  windowed_peak_to_peak_db_meter uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_peak_span(out_peak_span), .out_level_db(out_level_db),
    .out_bar_fill(out_bar_fill)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout, %0d readings still due", $time, board.pending());
    $display("** windowed_peak_to_peak_db_meter: FAILED **");
    $finish;
  end

  // result side: random stall, quiet streaks, and long hold-offs on request
  initial begin
    int hold_left;
    int clear_left;
    int hold_seen;
    hold_left = 0;
    clear_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (clear_left == 0 && $urandom_range(63) == 0) clear_left = $urandom_range(30, 8);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (clear_left > 0) begin
        out_stall <= 1'b0;
        clear_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_reading(out_peak_span, out_level_db, out_bar_fill);

  task automatic send_sample(input logic [ADC_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_sample(s);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one write transaction, then a read-back of the same register
  task automatic write_window(input logic [WIN_W-1:0] len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= CFG_DATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_window(len);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[WIN_W-1:0] !== len) begin
      $display("%0t: window_samples read expected %0d got %0d", $time, len, prdata[WIN_W-1:0]);
      board.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ADC_W-1:0] wave_sample(input int center, input int amp);
    int v;
    if ($urandom_range(99) < 8) return FULL_SCALE;
    v = center - amp + int'($urandom_range(2 * amp));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return ADC_W'(v);
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    unique case ($urandom_range(3))
      0: return 16'd1;
      1: return WIN_W'($urandom_range(8, 2));
      2: return WIN_W'($urandom_range(24, 9));
      default: return WIN_W'($urandom_range(64, 25));
    endcase
  endfunction

  task automatic random_bursts(input int n_items);
    int sent;
    int center;
    int amp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(1) == 0) begin
        settle();
        write_window(pick_window());
      end
      center = $urandom_range(4095);
      amp = 1 << $urandom_range(12);
      repeat ($urandom_range(40, 5)) begin
        send_sample(wave_sample(center, amp));
        sent++;
      end
    end
  endtask

  initial begin
    logic [ADC_W-1:0] pairs[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 11;
    recv_idle_pct <= 75;

    // single-sample windows: full scale alone gives zero span
    write_window(16'd1);
    send_sample(12'd0);
    send_sample(FULL_SCALE);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'd1);

    // two-sample windows: widest span, all rejected, tiny spans
    settle();
    write_window(16'd2);
    pairs = '{12'd0, 12'd4094, 12'd4094, 12'd0, FULL_SCALE, FULL_SCALE,
              12'd1, 12'd2, 12'd5, 12'd3, FULL_SCALE, 12'd17};
    foreach (pairs[i]) send_sample(pairs[i]);

    // first valid sample sets max and min together
    settle();
    write_window(16'd3);
    send_sample(12'd2000);
    send_sample(FULL_SCALE);
    send_sample(12'd2001);

    // window shortened below the count already taken
    settle();
    write_window(16'd5);
    send_sample(12'd10);
    send_sample(12'd20);
    send_sample(12'd30);
    settle();
    write_window(16'd2);
    send_sample(12'd40);

    random_bursts(170);

    // output held off while samples keep coming
    settle();
    write_window(16'd1);
    hold_req <= hold_req + 1;
    repeat (60) send_sample(ADC_W'($urandom_range(4095)));

    settle();
    send_idle_pct <= 75;
    recv_idle_pct <= 11;
    random_bursts(170);

    settle();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    random_bursts(170);

    // one long window
    settle();
    write_window(16'd120);
    repeat (120) send_sample(wave_sample(2048, 2048));

    settle();
    $display("Run covered %0d samples and %0d checked readings: windows from 1 to 120,",
             board.samples_taken, board.readings_checked);
    $display("full-scale rejects, mid-window shortening, input and output back-pressure.");
    if (board.failures == 0 && board.pending() == 0)
      $display("** windowed_peak_to_peak_db_meter: PASSED **");
    else
      $display("** windowed_peak_to_peak_db_meter: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wpp_pkg.sv
hw/rtl/wpp_tracker.sv
hw/rtl/wpp_level.sv
hw/rtl/windowed_peak_to_peak_db_meter.sv
test/windowed_peak_to_peak_db_meter_test.sv
